[sv/csu_pkg.sv]
package csu_pkg;

  // Accumulator width for the dot product and both squared norms
  localparam int AccBits = 41;

  // Width of the similarity result, signed Q1.15
  localparam int SimBits = 16;

  // Finished sums of one vector pair, handed from front to back
  typedef struct packed {
    logic signed [AccBits-1:0] dot;
    logic        [AccBits-1:0] norm_a;
    logic        [AccBits-1:0] norm_b;
  } sums_t;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/csu_front.sv]
module csu_front #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ELEMENT_BITS-1:0]  a_value_i,
  input  logic signed [ELEMENT_BITS-1:0]  b_value_i,
  input  logic                            last_i,
  input  csu_pkg::q_status_t              q_stat_i,
  output logic                            push_o,
  output csu_pkg::sums_t                  push_data_o
);

  localparam int ProdBits = 2 * ELEMENT_BITS;
  localparam int SumBits  =
    ((ProdBits > csu_pkg::AccBits) ? ProdBits : csu_pkg::AccBits) + 2;
  localparam logic signed [SumBits-1:0] DotMax =
    SumBits'((64'sd1 <<< (csu_pkg::AccBits - 1)) - 64'sd1);
  localparam logic signed [SumBits-1:0] DotMin =
    SumBits'(-(64'sd1 <<< (csu_pkg::AccBits - 1)));
  localparam logic [SumBits-1:0] NormMax =
    SumBits'((64'd1 << csu_pkg::AccBits) - 64'd1);

  logic                             prod_vld_q, prod_vld_d;
  logic                             prod_last_q;
  logic signed [ProdBits-1:0]       dot_prod_q, dot_prod_c;
  logic signed [ProdBits-1:0]       sq_a_c, sq_b_c;
  logic        [ProdBits-1:0]       sq_a_q, sq_b_q;
  logic signed [csu_pkg::AccBits-1:0] dot_q;
  logic        [csu_pkg::AccBits-1:0] na_q, nb_q;
  logic signed [SumBits-1:0]        dot_sum;
  logic        [SumBits-1:0]        na_sum, nb_sum;
  csu_pkg::sums_t                   new_sums;
  logic                             hold, take, adv;

  // A final item waiting on a full queue blocks the input
  assign hold       = prod_vld_q & prod_last_q & q_stat_i.full;
  assign in_stall_o = hold;
  assign take       = in_valid_i & ~hold;
  assign adv        = prod_vld_q & ~hold;

  // Products of the incoming pair
  assign dot_prod_c = a_value_i * b_value_i;
  assign sq_a_c     = a_value_i * a_value_i;
  assign sq_b_c     = b_value_i * b_value_i;

  assign prod_vld_d = take | (prod_vld_q & hold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= prod_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_last_q <= last_i;
      dot_prod_q  <= dot_prod_c;
      sq_a_q      <= unsigned'(sq_a_c);
      sq_b_q      <= unsigned'(sq_b_c);
    end
  end

  // Saturating accumulation
  assign dot_sum = SumBits'(dot_q) + SumBits'(dot_prod_q);
  assign na_sum  = SumBits'(na_q) + SumBits'(sq_a_q);
  assign nb_sum  = SumBits'(nb_q) + SumBits'(sq_b_q);

  always_comb begin
    priority if (dot_sum > DotMax) begin
      new_sums.dot = DotMax[csu_pkg::AccBits-1:0];
    end else if (dot_sum < DotMin) begin
      new_sums.dot = DotMin[csu_pkg::AccBits-1:0];
    end else begin
      new_sums.dot = dot_sum[csu_pkg::AccBits-1:0];
    end
    new_sums.norm_a = (na_sum > NormMax) ? NormMax[csu_pkg::AccBits-1:0]
                                         : na_sum[csu_pkg::AccBits-1:0];
    new_sums.norm_b = (nb_sum > NormMax) ? NormMax[csu_pkg::AccBits-1:0]
                                         : nb_sum[csu_pkg::AccBits-1:0];
  end

  assign push_o      = adv & prod_last_q;
  assign push_data_o = new_sums;

  // Accumulators clear once a vector's sums go to the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (adv) begin
      if (prod_last_q) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else begin
        dot_q <= new_sums.dot;
        na_q  <= new_sums.norm_a;
        nb_q  <= new_sums.norm_b;
      end
    end
  end

endmodule

[sv/csu_queue.sv]
module csu_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csu_pkg::sums_t     push_data_i,
  input  logic               pop_i,
  output csu_pkg::sums_t     pop_data_o,
  output csu_pkg::q_status_t status_o
);

  localparam int Depth   = 2;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  csu_pkg::sums_t       entries_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   cnt_q;

  // Pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntBits'(push_i) - CntBits'(pop_i);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = entries_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntBits'(Depth));
  assign status_o.empty = (cnt_q == '0);

endmodule

[sv/csu_back.sv]
module csu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csu_pkg::q_status_t                 q_stat_i,
  output logic                               pop_o,
  input  csu_pkg::sums_t                     pop_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [csu_pkg::SimBits-1:0] similarity_o,
  output logic                               zero_norm_o
);

  localparam int AccBits  = csu_pkg::AccBits;
  localparam int QBits    = csu_pkg::SimBits;
  localparam int CntBits  = $clog2(QBits);
  localparam int MulHalf  = (AccBits + 1) / 2;
  localparam int MulBits  = 2 * MulHalf;
  localparam int ProdW    = 2 * MulBits;
  localparam int SrchBits = 2 * AccBits + 2 * QBits + 3;
  localparam logic [QBits-1:0] SimPosMax = {1'b0, {(QBits-1){1'b1}}};

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMulP = 5'b00010,
    StMulD = 5'b00100,
    StSrch = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [CntBits-1:0]           cnt_q, cnt_d;
  logic                         neg_q, neg_d;
  logic [AccBits-1:0]           mag_q, mag_d;
  logic [MulBits-1:0]           mul_x_q, mul_x_d, mul_y_q, mul_y_d;
  logic [ProdW-1:0]             acc_q, acc_d;
  logic signed [SrchBits-1:0]   x_q, x_d, z_q, z_d, pa_q, pa_d, r_q, r_d;
  logic [QBits-1:0]             q_q, q_d;
  logic [QBits-1:0]             res_sim_q, res_sim_d;
  logic                         res_zero_q, res_zero_d;
  logic                         out_vld_q, out_vld_d;
  logic [QBits-1:0]             out_sim_q, out_sim_d;
  logic                         out_zero_q, out_zero_d;

  logic [MulHalf-1:0]           mx, my;
  logic [MulBits-1:0]           pp;
  logic [ProdW-1:0]             pp_sh, acc_next;
  logic                         mul_last;
  logic signed [SrchBits-1:0]   p_ext, x_t, z_up, z_keep;
  logic                         accept;
  logic [QBits-1:0]             q_trial, q_fin;
  logic [AccBits-1:0]           dot_bits, mag_c;
  logic                         zero_norm_c;

  // Shared multiplier: one 21x21 partial product per cycle, four per product
  assign mx = cnt_q[1] ? mul_x_q[MulBits-1:MulHalf] : mul_x_q[MulHalf-1:0];
  assign my = cnt_q[0] ? mul_y_q[MulBits-1:MulHalf] : mul_y_q[MulHalf-1:0];
  assign pp = mx * my;

  always_comb begin
    unique case (cnt_q[1:0])
      2'b00:        pp_sh = ProdW'(pp);
      2'b01, 2'b10: pp_sh = ProdW'(pp) << MulHalf;
      default:      pp_sh = ProdW'(pp) << MulBits;
    endcase
  end

  assign acc_next = acc_q + pp_sh;
  assign mul_last = (cnt_q[1:0] == 2'b11);
  assign p_ext    = $signed({{(SrchBits-2*AccBits){1'b0}}, acc_next[2*AccBits-1:0]});

  // Search step: X = k^2*P, Z = k*P scaled, Pa = P scaled, with k = 2q-1
  assign x_t     = x_q + z_q + pa_q;
  assign accept  = ~q_q[QBits-1] & (x_t <= r_q);
  assign q_trial = q_q | (QBits'(1) << cnt_q);
  assign z_up    = (z_q + (pa_q <<< 1)) >>> 1;
  assign z_keep  = z_q >>> 1;
  assign q_fin   = accept ? q_trial : q_q;

  // Head of queue classification
  assign dot_bits    = pop_data_i.dot;
  assign mag_c       = dot_bits[AccBits-1] ? (~dot_bits + 1'b1) : dot_bits;
  assign zero_norm_c = (pop_data_i.norm_a == '0) | (pop_data_i.norm_b == '0);

  assign pop_o = (state_q == StIdle) & ~q_stat_i.empty;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    mul_x_d    = mul_x_q;
    mul_y_d    = mul_y_q;
    acc_d      = acc_q;
    x_d        = x_q;
    z_d        = z_q;
    pa_d       = pa_q;
    r_d        = r_q;
    q_d        = q_q;
    res_sim_d  = res_sim_q;
    res_zero_d = res_zero_q;
    out_vld_d  = out_vld_q & out_stall_i;
    out_sim_d  = out_sim_q;
    out_zero_d = out_zero_q;

    unique case (state_q)
      StIdle: begin
        if (!q_stat_i.empty) begin
          neg_d = dot_bits[AccBits-1];
          mag_d = mag_c;
          if (zero_norm_c) begin
            res_sim_d  = '0;
            res_zero_d = 1'b1;
            state_d    = StDone;
          end else if (dot_bits == '0) begin
            res_sim_d  = '0;
            res_zero_d = 1'b0;
            state_d    = StDone;
          end else begin
            mul_x_d = MulBits'(pop_data_i.norm_a);
            mul_y_d = MulBits'(pop_data_i.norm_b);
            acc_d   = '0;
            cnt_d   = '0;
            state_d = StMulP;
          end
        end
      end
      StMulP: begin
        acc_d = acc_next;
        cnt_d = cnt_q + 1'b1;
        if (mul_last) begin
          // P = normA * normB, start point q = 0
          x_d     = p_ext;
          z_d     = -(p_ext <<< (QBits + 1));
          pa_d    = p_ext <<< (2 * QBits);
          mul_x_d = MulBits'(mag_q);
          mul_y_d = MulBits'(mag_q);
          acc_d   = '0;
          cnt_d   = '0;
          state_d = StMulD;
        end
      end
      StMulD: begin
        acc_d = acc_next;
        cnt_d = cnt_q + 1'b1;
        if (mul_last) begin
          r_d     = p_ext <<< (2 * QBits);
          q_d     = '0;
          cnt_d   = CntBits'(QBits - 1);
          state_d = StSrch;
        end
      end
      StSrch: begin
        pa_d = pa_q >>> 2;
        if (accept) begin
          x_d = x_t;
          q_d = q_trial;
          z_d = z_up;
        end else begin
          z_d = z_keep;
        end
        if (cnt_q == '0) begin
          if (neg_q) begin
            res_sim_d = ~q_fin + 1'b1;
          end else begin
            res_sim_d = q_fin[QBits-1] ? SimPosMax : q_fin;
          end
          res_zero_d = 1'b0;
          state_d    = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_sim_d  = res_sim_q;
          out_zero_d = res_zero_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    mul_x_q    <= mul_x_d;
    mul_y_q    <= mul_y_d;
    acc_q      <= acc_d;
    x_q        <= x_d;
    z_q        <= z_d;
    pa_q       <= pa_d;
    r_q        <= r_d;
    q_q        <= q_d;
    res_sim_q  <= res_sim_d;
    res_zero_q <= res_zero_d;
    out_sim_q  <= out_sim_d;
    out_zero_q <= out_zero_d;
  end

  assign out_valid_o  = out_vld_q;
  assign similarity_o = $signed(out_sim_q);
  assign zero_norm_o  = out_zero_q;

endmodule

[sv/cosine_similarity_unit.sv]
// Streaming cosine similarity of two vectors.
// Input channel (in_valid_i / in_stall_o): one element pair a_value_i,
// b_value_i per item, last_i set on the final pair of the vectors. Pairs
// are taken one per cycle while in_stall_o is low; the dot product and
// both squared norms are accumulated with saturation and cleared after the
// final pair. Output channel (out_valid_o / out_stall_i): one item per
// vector pair, similarity_o in Q1.15 rounded to nearest, zero_norm_o set
// (and similarity 0) when either norm is zero.
// After the final pair the front registers the products and pushes the
// sums; the back unit then forms normA*normB and dot^2 on its shared 21x21
// multiplier and runs a bit-by-bit rounding search. A zero norm or zero
// dot product skips the multiplier and the search.
// Finished sums wait in a two-entry queue; the back unit takes new sums
// only when idle, so it paces short vectors, long ones stream at full rate.
// A stalled receiver holds the result; the back unit then waits with the
// next result and the queue fills, after which in_stall_o rises on a final
// pair. Reset clears the accumulators, the queue and the output valid.
module cosine_similarity_unit #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ELEMENT_BITS-1:0]     a_value_i,
  input  logic signed [ELEMENT_BITS-1:0]     b_value_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [csu_pkg::SimBits-1:0] similarity_o,
  output logic                               zero_norm_o
);

  csu_pkg::q_status_t q_stat;
  csu_pkg::sums_t     push_data, pop_data;
  logic               push, pop;

  // Accumulating front
  csu_front #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_value_i   (a_value_i),
    .b_value_i   (b_value_i),
    .last_i      (last_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Sums queue between front and back
  csu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_stat)
  );

  // Ratio and rounding back end
  csu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o)
  );

endmodule
